@@ design/dlin_pkg.sv @@
// Shared types and constants for the 3D line distance block.
package dlin_pkg;

    // Input transaction: two lines, each a point and a direction, signed fixed point
    typedef struct packed {
        logic signed [31:0] line_a_point_x;
        logic signed [31:0] line_a_point_y;
        logic signed [31:0] line_a_point_z;
        logic signed [31:0] line_a_dir_x;
        logic signed [31:0] line_a_dir_y;
        logic signed [31:0] line_a_dir_z;
        logic signed [31:0] line_b_point_x;
        logic signed [31:0] line_b_point_y;
        logic signed [31:0] line_b_point_z;
        logic signed [31:0] line_b_dir_x;
        logic signed [31:0] line_b_dir_y;
        logic signed [31:0] line_b_dir_z;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [31:0] distance;
        logic [1:0]  case_code;
    } t_out;

    // Case codes
    localparam logic [1:0] CASE_GENERAL  = 2'd0;
    localparam logic [1:0] CASE_PARALLEL = 2'd1;
    localparam logic [1:0] CASE_ZERO_DIR = 2'd2;

    // Latency of the limb multiplier in cycles
    localparam int MUL_LAT = 4;

    // Widths of the exact intermediate values
    localparam int DENW = 132; // |n|^2 or |dir_a|^2
    localparam int NUMW = 200; // (u.n)^2 or |u x dir_a|^2
    localparam int YW   = 164; // q * den in the root search
    localparam int TW   = 201; // trial subtrahend in the root search
    localparam int QW   = 32;  // result bits, one per root stage

endpackage

@@ design/dlin_mul.sv @@
// Pipelined signed multiplier built from 32x32 limb products.
module dlin_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                     i_clk,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int PA = NA * 32;
    localparam int PB = NB * 32;
    localparam int PW = PA + PB;

    logic [AW-1:0]    n_abs_a;
    logic [BW-1:0]    n_abs_b;
    logic [PA-1:0]    r_ma;
    logic [PB-1:0]    r_mb;
    logic             r_neg1;
    logic [63:0]      r_pp [NA][NB];
    logic             r_neg2;
    logic [PW-1:0]    n_row [NA];
    logic [PW-1:0]    r_row [NA];
    logic             r_neg3;
    logic [PW-1:0]    n_sum;
    logic [PW-1:0]    n_p;
    logic [AW+BW-1:0] r_p;

    // Take magnitudes and the product sign
    always_comb begin
        n_abs_a = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
        n_abs_b = i_b[BW-1] ? (~i_b + 1'b1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= PA'(n_abs_a);
        r_mb   <= PB'(n_abs_b);
        r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
    end

    // Form every limb product
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= 64'(r_ma[i*32 +: 32]) * 64'(r_mb[j*32 +: 32]);
            end
        end
        r_neg2 <= r_neg1;
    end

    // Sum each row of partial products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (32 * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_neg3 <= r_neg2;
    end

    // Sum the rows and restore the sign
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] << (32 * i));
        end
        n_p = r_neg3 ? (~n_sum + 1'b1) : n_sum;
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p[AW+BW-1:0];
    end

    assign o_p = $signed(r_p);

endmodule

@@ design/distance_between_3d_lines.sv @@
// Top level: shortest distance between two 3D lines, fully pipelined.
//
// Usage:
//   Drive a transaction on i_item and raise start; it is taken at the rising
//   edge where start is high and busy is low. busy stays low, so a new
//   transaction may enter on every clock cycle.
//   Each result appears on o_result for exactly one cycle with o_done high,
//   in the order of entry. The pipeline is made of three limb multiplier
//   passes, the registers between them and a 32-stage root search (one
//   result bit per stage). Throughput is one transaction per cycle.
//   case_code gives general, parallel or zero first direction; for a zero
//   first direction the distance reads zero. Distances saturate at all ones.
//   The receiver cannot stall: results are never held back.
//   Synchronous reset clears every valid bit; no result is issued for
//   transactions in flight at reset.
module distance_between_3d_lines (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dlin_pkg::t_in   i_item,
    output logic            o_done,
    output dlin_pkg::t_out  o_result
);

    localparam int ML = dlin_pkg::MUL_LAT;
    localparam int NQ = dlin_pkg::QW;

    typedef struct packed {
        logic signed [32:0] u0;
        logic signed [32:0] u1;
        logic signed [32:0] u2;
        logic               az;
    } t_aux1;

    typedef struct packed {
        logic [65:0] denp;
        logic        az;
    } t_aux2;

    typedef struct packed {
        logic [dlin_pkg::DENW-1:0] deng;
        logic [133:0]              nump;
        logic [65:0]               denp;
        logic                      az;
    } t_aux3;

    typedef struct packed {
        logic [1:0]                code;
        logic [NQ-1:0]             q;
        logic [dlin_pkg::NUMW-1:0] rem;
        logic [dlin_pkg::YW-1:0]   y;
        logic [dlin_pkg::DENW-1:0] den;
    } t_root;

    // Stage A: difference vector and directions
    logic               w_take;
    logic               r_va;
    logic signed [32:0] r_u  [3];
    logic signed [31:0] r_da [3];
    logic signed [31:0] r_db [3];
    logic               r_az;

    // First multiplier pass
    logic signed [63:0] w_nab [3];
    logic signed [63:0] w_nba [3];
    logic signed [64:0] w_wua [3];
    logic signed [64:0] w_wau [3];
    logic signed [63:0] w_aa  [3];
    logic [ML-1:0]      r_v1;
    t_aux1              r_d1 [ML];

    // Stage B
    logic               r_vb;
    logic signed [64:0] r_n  [3];
    logic signed [65:0] r_w  [3];
    logic signed [32:0] r_ub [3];
    logic [65:0]        r_denp;
    logic               r_azb;

    // Second multiplier pass
    logic signed [129:0] w_nn [3];
    logic signed [131:0] w_ww [3];
    logic signed [97:0]  w_un [3];
    logic [ML-1:0]       r_v2;
    t_aux2               r_d2 [ML];

    // Stage C
    logic                      r_vc;
    logic [dlin_pkg::DENW-1:0] r_deng;
    logic [133:0]              r_nump;
    logic signed [99:0]        r_s;
    logic [65:0]               r_denpc;
    logic                      r_azc;

    // Third multiplier pass
    logic signed [199:0] w_ss;
    logic [ML-1:0]       r_v3;
    t_aux3               r_d3 [ML];

    // Root search
    logic                      w_par;
    t_root                     n_rs [NQ+1];
    t_root                     r_rs [NQ+1];
    logic [NQ:0]               r_rv;
    logic [dlin_pkg::TW-1:0]   w_t  [NQ];

    // Output register
    logic           r_ov;
    dlin_pkg::t_out r_out;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    // Capture a transaction: form u = point_b - point_a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u[0]  <= 33'(i_item.line_b_point_x) - 33'(i_item.line_a_point_x);
        r_u[1]  <= 33'(i_item.line_b_point_y) - 33'(i_item.line_a_point_y);
        r_u[2]  <= 33'(i_item.line_b_point_z) - 33'(i_item.line_a_point_z);
        r_da[0] <= i_item.line_a_dir_x;
        r_da[1] <= i_item.line_a_dir_y;
        r_da[2] <= i_item.line_a_dir_z;
        r_db[0] <= i_item.line_b_dir_x;
        r_db[1] <= i_item.line_b_dir_y;
        r_db[2] <= i_item.line_b_dir_z;
        r_az    <= (i_item.line_a_dir_x == '0) && (i_item.line_a_dir_y == '0)
                   && (i_item.line_a_dir_z == '0);
    end

    // First pass: cross products and |dir_a|^2 terms
    for (genvar i = 0; i < 3; i++) begin : g_m1
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        dlin_mul #(.AW(32), .BW(32)) u_nab (
            .i_clk(i_clk), .i_a(r_da[J]), .i_b(r_db[K]), .o_p(w_nab[i])
        );
        dlin_mul #(.AW(32), .BW(32)) u_nba (
            .i_clk(i_clk), .i_a(r_da[K]), .i_b(r_db[J]), .o_p(w_nba[i])
        );
        dlin_mul #(.AW(33), .BW(32)) u_wua (
            .i_clk(i_clk), .i_a(r_u[J]), .i_b(r_da[K]), .o_p(w_wua[i])
        );
        dlin_mul #(.AW(33), .BW(32)) u_wau (
            .i_clk(i_clk), .i_a(r_u[K]), .i_b(r_da[J]), .o_p(w_wau[i])
        );
        dlin_mul #(.AW(32), .BW(32)) u_aa (
            .i_clk(i_clk), .i_a(r_da[i]), .i_b(r_da[i]), .o_p(w_aa[i])
        );
    end

    // Carry u and the zero flag alongside the first pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= '0;
        end else begin
            r_v1 <= {r_v1[ML-2:0], r_va};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1[0] <= '{u0: r_u[0], u1: r_u[1], u2: r_u[2], az: r_az};
        for (int k = 1; k < ML; k++) begin
            r_d1[k] <= r_d1[k-1];
        end
    end

    // Stage B: finish the cross products and |dir_a|^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_v1[ML-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_n[i] <= 65'(w_nab[i]) - 65'(w_nba[i]);
            r_w[i] <= 66'(w_wua[i]) - 66'(w_wau[i]);
        end
        r_ub[0] <= r_d1[ML-1].u0;
        r_ub[1] <= r_d1[ML-1].u1;
        r_ub[2] <= r_d1[ML-1].u2;
        r_azb   <= r_d1[ML-1].az;
        r_denp  <= 66'($unsigned(w_aa[0])) + 66'($unsigned(w_aa[1]))
                   + 66'($unsigned(w_aa[2]));
    end

    // Second pass: squares of n and w, and u.n terms
    for (genvar i = 0; i < 3; i++) begin : g_m2
        dlin_mul #(.AW(65), .BW(65)) u_nn (
            .i_clk(i_clk), .i_a(r_n[i]), .i_b(r_n[i]), .o_p(w_nn[i])
        );
        dlin_mul #(.AW(66), .BW(66)) u_ww (
            .i_clk(i_clk), .i_a(r_w[i]), .i_b(r_w[i]), .o_p(w_ww[i])
        );
        dlin_mul #(.AW(33), .BW(65)) u_un (
            .i_clk(i_clk), .i_a(r_ub[i]), .i_b(r_n[i]), .o_p(w_un[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= '0;
        end else begin
            r_v2 <= {r_v2[ML-2:0], r_vb};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2[0] <= '{denp: r_denp, az: r_azb};
        for (int k = 1; k < ML; k++) begin
            r_d2[k] <= r_d2[k-1];
        end
    end

    // Stage C: sum the dot products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_v2[ML-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_deng  <= dlin_pkg::DENW'($unsigned(w_nn[0])) + dlin_pkg::DENW'($unsigned(w_nn[1]))
                   + dlin_pkg::DENW'($unsigned(w_nn[2]));
        r_nump  <= 134'($unsigned(w_ww[0])) + 134'($unsigned(w_ww[1]))
                   + 134'($unsigned(w_ww[2]));
        r_s     <= 100'(w_un[0]) + 100'(w_un[1]) + 100'(w_un[2]);
        r_denpc <= r_d2[ML-1].denp;
        r_azc   <= r_d2[ML-1].az;
    end

    // Third pass: square of u.n
    dlin_mul #(.AW(100), .BW(100)) u_ss (
        .i_clk(i_clk), .i_a(r_s), .i_b(r_s), .o_p(w_ss)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= '0;
        end else begin
            r_v3 <= {r_v3[ML-2:0], r_vc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d3[0] <= '{deng: r_deng, nump: r_nump, denp: r_denpc, az: r_azc};
        for (int k = 1; k < ML; k++) begin
            r_d3[k] <= r_d3[k-1];
        end
    end

    // Stage D picks the case; each root stage then tries one result bit
    assign w_par = (r_d3[ML-1].deng == '0);

    always_comb begin
        n_rs[0].q = '0;
        n_rs[0].y = '0;
        if (w_par) begin
            n_rs[0].rem = dlin_pkg::NUMW'(r_d3[ML-1].nump);
            n_rs[0].den = dlin_pkg::DENW'(r_d3[ML-1].denp);
        end else begin
            n_rs[0].rem = $unsigned(w_ss);
            n_rs[0].den = r_d3[ML-1].deng;
        end
        if (r_d3[ML-1].az) begin
            n_rs[0].code = dlin_pkg::CASE_ZERO_DIR;
        end else if (w_par) begin
            n_rs[0].code = dlin_pkg::CASE_PARALLEL;
        end else begin
            n_rs[0].code = dlin_pkg::CASE_GENERAL;
        end

        // Trial: (q + 2^b)^2 den - q^2 den = 2^(b+1) q den + 2^(2b) den
        for (int k = 0; k < NQ; k++) begin
            n_rs[k+1] = r_rs[k];
            w_t[k] = (dlin_pkg::TW'(r_rs[k].y) << (NQ - k))
                   + (dlin_pkg::TW'(r_rs[k].den) << (2 * (NQ - 1 - k)));
            if (w_t[k] <= dlin_pkg::TW'(r_rs[k].rem)) begin
                n_rs[k+1].rem         = r_rs[k].rem - w_t[k][dlin_pkg::NUMW-1:0];
                n_rs[k+1].y           = r_rs[k].y
                                        + (dlin_pkg::YW'(r_rs[k].den) << (NQ - 1 - k));
                n_rs[k+1].q[NQ-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else begin
            r_rv <= {r_rv[NQ-1:0], r_v3[ML-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NQ; k++) begin
            r_rs[k] <= n_rs[k];
        end
    end

    // Drive the result strobe; zero the distance for a zero first direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_rv[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.case_code <= r_rs[NQ].code;
        r_out.distance  <= (r_rs[NQ].code == dlin_pkg::CASE_ZERO_DIR) ? '0 : r_rs[NQ].q;
    end

    assign o_done   = r_ov;
    assign o_result = r_out;

endmodule

@@ tb/sv/distance_between_3d_lines_tb.sv @@
// Testbench for the 3D line distance block: directed and random line pairs against a predictor.
`timescale 1ns / 100ps

module distance_between_3d_lines_tb;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    dlin_pkg::t_in    i_item;
    logic             o_done;
    dlin_pkg::t_out   o_result;

    dlin_pkg::t_out   dist_expected_q[$];
    int               mismatch_count;
    int               unexpected_count;
    int               sent_count;

    distance_between_3d_lines DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Clock: 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Largest q with q*q*den <= num, saturating at all ones
    function automatic logic [31:0] root_of_quotient(logic [255:0] num, logic [255:0] den);
        logic [31:0]  q;
        logic [31:0]  t;
        logic [255:0] p;
        q = '0;
        for (int b = 31; b >= 0; b--) begin
            t = q | (32'd1 << b);
            p = 256'(t) * 256'(t) * den;
            if (p <= num) q = t;
        end
        return q;
    endfunction

    // Exact distance between the two lines
    function automatic dlin_pkg::t_out line_distance(dlin_pkg::t_in it);
        logic signed [255:0] u[3], da[3], db[3], n[3], w[3], s;
        logic [255:0]        num, den;
        dlin_pkg::t_out      r;
        u[0]  = 256'(signed'(it.line_b_point_x)) - 256'(signed'(it.line_a_point_x));
        u[1]  = 256'(signed'(it.line_b_point_y)) - 256'(signed'(it.line_a_point_y));
        u[2]  = 256'(signed'(it.line_b_point_z)) - 256'(signed'(it.line_a_point_z));
        da[0] = 256'(signed'(it.line_a_dir_x));
        da[1] = 256'(signed'(it.line_a_dir_y));
        da[2] = 256'(signed'(it.line_a_dir_z));
        db[0] = 256'(signed'(it.line_b_dir_x));
        db[1] = 256'(signed'(it.line_b_dir_y));
        db[2] = 256'(signed'(it.line_b_dir_z));
        if (it.line_a_dir_x == 0 && it.line_a_dir_y == 0 && it.line_a_dir_z == 0) begin
            r.distance  = '0;
            r.case_code = dlin_pkg::CASE_ZERO_DIR;
            return r;
        end
        n[0] = da[1] * db[2] - da[2] * db[1];
        n[1] = da[2] * db[0] - da[0] * db[2];
        n[2] = da[0] * db[1] - da[1] * db[0];
        den  = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        if (den == 0) begin
            w[0] = u[1] * da[2] - u[2] * da[1];
            w[1] = u[2] * da[0] - u[0] * da[2];
            w[2] = u[0] * da[1] - u[1] * da[0];
            num  = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
            den  = da[0] * da[0] + da[1] * da[1] + da[2] * da[2];
            r.case_code = dlin_pkg::CASE_PARALLEL;
        end else begin
            s   = u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
            num = s * s;
            r.case_code = dlin_pkg::CASE_GENERAL;
        end
        r.distance = root_of_quotient(num, den);
        return r;
    endfunction

    // Send one transaction and queue its expected result; start stays high for the next one
    task automatic send_lines(dlin_pkg::t_in it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        dist_expected_q.push_back(line_distance(it));
        sent_count++;
    endtask

    // Random gap between bursts; zero most of the time
    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'(signed'($urandom_range(0, 2000)) - 1000) << 16;
            2:       return 32'(signed'($urandom_range(0, 20)) - 10);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    function automatic dlin_pkg::t_in rand_lines();
        dlin_pkg::t_in it;
        int            mode;
        mode = $urandom_range(0, 3);
        it = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        return it;
    endfunction

    // Extremes, zero directions, parallel and coincident lines
    task automatic test_directed();
        logic [31:0]   mx, mn, one;
        dlin_pkg::t_in it;
        mx  = 32'h7FFF_FFFF;
        mn  = 32'h8000_0000;
        one = 32'h0001_0000;
        it = '0;
        send_lines(it);
        it = '{default: mx};
        send_lines(it);
        it = '{default: mn};
        send_lines(it);
        it = {mn, mn, mn, one, 32'd0, 32'd0, mx, mx, mx, 32'd0, one, 32'd0};
        send_lines(it);
        it = {mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx};
        send_lines(it);
        it = {mn, mx, mn, mn, 32'd0, mx, mx, mn, mx, mx, mn, 32'd0};
        send_lines(it);
        // zero first direction, second nonzero
        it = {one, one, one, 32'd0, 32'd0, 32'd0, 32'd5, 32'd6, 32'd7, one, one, one};
        send_lines(it);
        // zero second direction
        it = {32'd0, 32'd0, 32'd0, one, one, 32'd0, one, 32'd0, one, 32'd0, 32'd0, 32'd0};
        send_lines(it);
        // parallel, opposite direction, scaled
        it = {32'd0, 32'd0, 32'd0, one, one, one, 32'd0, one, 32'd0, -2 * one, -2 * one,
              -2 * one};
        send_lines(it);
        // coincident lines
        it = {one, one, one, one, 32'd0, 32'd0, 3 * one, one, one, one, 32'd0, 32'd0};
        send_lines(it);
        // intersecting lines
        it = {32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0};
        send_lines(it);
        // skew, unit spacing
        it = {32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, 32'd0, one, 32'd0, one, 32'd0};
        send_lines(it);
        // huge result saturates
        it = {mn, mn, mn, 32'd1, 32'd0, 32'd0, mx, mx, mx, 32'd0, 32'd1, 32'd0};
        send_lines(it);
        // parallel with extreme directions
        it = {mn, 32'd0, mx, mx, mn, mx, mx, mn, 32'd0, mx, mn, mx};
        send_lines(it);
        it = {32'd0, 32'd0, 32'd0, mn, 32'd0, 32'd0, mx, mx, mn, 32'd1, 32'd0, 32'd0};
        send_lines(it);
    endtask

    // Random line pairs, some forced parallel or with zero directions
    task automatic test_random(int count);
        dlin_pkg::t_in it;
        int            burst;
        int            k;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && k < count; j++) begin
                it = rand_lines();
                case ($urandom_range(0, 9))
                    0: begin
                        it.line_b_dir_x = it.line_a_dir_x;
                        it.line_b_dir_y = it.line_a_dir_y;
                        it.line_b_dir_z = it.line_a_dir_z;
                    end
                    1: begin
                        it.line_b_dir_x = -it.line_a_dir_x;
                        it.line_b_dir_y = -it.line_a_dir_y;
                        it.line_b_dir_z = -it.line_a_dir_z;
                    end
                    2: {it.line_a_dir_x, it.line_a_dir_y, it.line_a_dir_z} = '0;
                    3: {it.line_b_dir_x, it.line_b_dir_y, it.line_b_dir_z} = '0;
                    default: ;
                endcase
                send_lines(it);
                k++;
            end
            sender_gap();
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        dlin_pkg::t_out exp_r;
        if (i_rst_n && o_done) begin
            if (dist_expected_q.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result: distance %h case %0d",
                             o_result.distance, o_result.case_code);
            end else begin
                exp_r = dist_expected_q.pop_front();
                if (o_result.distance !== exp_r.distance
                        || o_result.case_code !== exp_r.case_code) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch: expected distance %h case %0d, got %h case %0d",
                                 exp_r.distance, exp_r.case_code,
                                 o_result.distance, o_result.case_code);
                end
            end
        end
    end

    // Hard stop after a generous time
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int drain;
        mismatch_count   = 0;
        unexpected_count = 0;
        sent_count       = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1700);
        start <= 1'b0;
        // drain the pipeline
        drain = 0;
        while (dist_expected_q.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0 && dist_expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
